[src/tfd_pkg.sv]
// tfd_pkg: shared types and constants of the touch frame decoder
// used by every module under src, no dependencies
`default_nettype none

package tfd_pkg;

    // frame layout
    localparam int FRAME_BYTES = 8;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    // field widths
    localparam int RAW_W  = 12;
    localparam int GAIN_W = 18;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = 18;
    localparam int IDX_W  = 2;

    // input modes
    localparam logic [1:0] MODE_BYTE   = 2'd0;
    localparam logic [1:0] MODE_RXFAIL = 2'd1;
    localparam logic [1:0] MODE_POLL   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_POINTER  = 2'd0;
    localparam logic [1:0] KIND_CHECKSUM = 2'd1;
    localparam logic [1:0] KIND_RXFAIL   = 2'd2;
    localparam logic [1:0] KIND_POLL     = 2'd3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_X_MIN  = 2'd0;
    localparam logic [IDX_W-1:0] REG_Y_MIN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_X_GAIN = 2'd2;
    localparam logic [IDX_W-1:0] REG_Y_GAIN = 2'd3;

    // register reset values
    localparam logic [RAW_W-1:0]  X_MIN_RESET  = 12'd440;
    localparam logic [RAW_W-1:0]  Y_MIN_RESET  = 12'd632;
    localparam logic [GAIN_W-1:0] X_GAIN_RESET = 18'd86675;
    localparam logic [GAIN_W-1:0] Y_GAIN_RESET = 18'd101757;

    // frame header bytes
    localparam logic [7:0] HDR_POINTER = 8'hEE;
    localparam logic [7:0] HDR_ACK0    = 8'hC8;
    localparam logic [7:0] HDR_ACK1    = 8'hCA;
    localparam logic [7:0] BTN_PRESSED = 8'h51;
    localparam logic [7:0] COORD_MASK  = 8'h3F;

    // input beat
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } t_in;

    // result beat
    typedef struct packed {
        logic [1:0]               event_kind;
        logic                     pressed;
        logic signed [FRAC_W-1:0] x_fraction;
        logic signed [FRAC_W-1:0] y_fraction;
    } t_out;

    // decoded frame event from the framer to the scaling stages
    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic             pressed;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } t_frame_ev;

endpackage

`default_nettype wire

[src/tfd_framer.sv]
// tfd_framer: byte framing, checksum check, header decode and poll flag
// depends on tfd_pkg
`default_nettype none

module tfd_framer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic               i_accept,
    input  wire tfd_pkg::t_in       i_in,
    output tfd_pkg::t_frame_ev      o_ev
);

    logic [tfd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                r_xor, n_xor;
    logic                      r_wait, n_wait;
    logic [7:0]                r_store [tfd_pkg::STORE_DEPTH];
    logic                      n_store_we;
    tfd_pkg::t_frame_ev        r_ev, n_ev;

    // next state and event for one accepted beat
    always_comb begin
        n_pos      = r_pos;
        n_xor      = r_xor;
        n_wait     = r_wait;
        n_store_we = 1'b0;
        n_ev.valid   = 1'b0;
        n_ev.kind    = tfd_pkg::KIND_POINTER;
        n_ev.pressed = (r_store[2] == tfd_pkg::BTN_PRESSED);
        n_ev.raw_x   = {r_store[5][5:0] & tfd_pkg::COORD_MASK[5:0],
                        r_store[6][5:0] & tfd_pkg::COORD_MASK[5:0]};
        n_ev.raw_y   = {r_store[3][5:0] & tfd_pkg::COORD_MASK[5:0],
                        r_store[4][5:0] & tfd_pkg::COORD_MASK[5:0]};
        if (i_accept) begin
            case (i_in.mode)
                tfd_pkg::MODE_RXFAIL: begin
                    n_pos      = '0;
                    n_xor      = '0;
                    n_ev.valid = 1'b1;
                    n_ev.kind  = tfd_pkg::KIND_RXFAIL;
                end
                tfd_pkg::MODE_POLL: begin
                    if (!r_wait) begin
                        n_wait     = 1'b1;
                        n_ev.valid = 1'b1;
                        n_ev.kind  = tfd_pkg::KIND_POLL;
                    end
                end
                tfd_pkg::MODE_BYTE: begin
                    if (r_pos < tfd_pkg::POS_W'(tfd_pkg::STORE_DEPTH)) begin
                        n_store_we = 1'b1;
                        n_xor      = r_xor ^ i_in.rx_byte;
                        n_pos      = r_pos + 1'b1;
                    end else begin
                        n_pos = '0;
                        n_xor = '0;
                        if (r_xor != i_in.rx_byte) begin
                            n_ev.valid = 1'b1;
                            n_ev.kind  = tfd_pkg::KIND_CHECKSUM;
                        end else if (r_store[0] == tfd_pkg::HDR_POINTER &&
                                     r_store[1] == tfd_pkg::HDR_POINTER) begin
                            n_ev.valid = 1'b1;
                            n_ev.kind  = tfd_pkg::KIND_POINTER;
                            n_wait     = 1'b0;
                        end else if (r_store[0] == tfd_pkg::HDR_ACK0 &&
                                     r_store[1] == tfd_pkg::HDR_ACK1) begin
                            n_wait = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // framing control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_xor  <= '0;
            r_wait <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_xor  <= n_xor;
            r_wait <= n_wait;
        end
    end

    // frame byte store, written at the current byte position
    always_ff @(posedge i_clk) begin
        if (n_store_we) begin
            r_store[r_pos] <= i_in.rx_byte;
        end
    end

    // event register, moves with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev.valid <= 1'b0;
        end else if (i_adv) begin
            r_ev <= n_ev;
        end
    end

    assign o_ev = r_ev;

endmodule

`default_nettype wire

[src/tfd_scaler.sv]
// tfd_scaler: one axis, offset and reciprocal-gain multiply, then round and saturate
// depends on tfd_pkg
`default_nettype none

module tfd_scaler (
    input  wire logic                               i_clk,
    input  wire logic                               i_adv,
    input  wire logic                               i_zero,
    input  wire logic [tfd_pkg::RAW_W-1:0]          i_raw,
    input  wire logic [tfd_pkg::RAW_W-1:0]          i_minimum,
    input  wire logic [tfd_pkg::GAIN_W-1:0]         i_gain,
    output logic signed [tfd_pkg::FRAC_W-1:0]       o_frac
);

    localparam int D_W    = tfd_pkg::RAW_W + 1;
    localparam int P_W    = 32;
    localparam int SHIFT  = 14;
    localparam int Q_W    = P_W + 1 - SHIFT;
    localparam int FW     = tfd_pkg::FRAC_W;

    logic [D_W-1:0]        n_diff;
    logic [P_W-1:0]        n_prod, r_prod;
    logic                  r_zero;
    logic [P_W:0]          n_sum;
    logic [Q_W-1:0]        n_q;
    logic [FW-1:0]         n_frac, r_frac;

    // signed offset and product, low bits of two's complement product
    always_comb begin
        n_diff = {1'b0, i_raw} - {1'b0, i_minimum};
        n_prod = {{(P_W-D_W){n_diff[D_W-1]}}, n_diff} *
                 {{(P_W-tfd_pkg::GAIN_W){1'b0}}, i_gain};
    end

    // round half up, floor shift, saturate to 16 bits
    always_comb begin
        n_sum = {r_prod[P_W-1], r_prod} + (P_W+1)'(1 << (SHIFT - 1));
        n_q   = n_sum[P_W:SHIFT];
        if (n_q[Q_W-1:FW-1] != {(Q_W-FW+1){n_q[Q_W-1]}}) begin
            n_frac = n_q[Q_W-1] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
        end else begin
            n_frac = n_q[FW-1:0];
        end
        if (r_zero) begin
            n_frac = '0;
        end
    end

    // product stage and result stage
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
            r_zero <= i_zero;
            r_frac <= n_frac;
        end
    end

    assign o_frac = $signed(r_frac);

endmodule

`default_nettype wire

[src/touch_frame_decoder_top.sv]
// touch_frame_decoder_top: serial touch-board frame decoder, top level
// depends on tfd_pkg, tfd_framer and tfd_scaler
//
// Input channel: one beat per received byte, receive failure or poll tick
// (i_in_valid, i_in_data, o_in_stall). Output channel: one beat per pointer
// position, checksum error, receive failure or poll request
// (o_out_valid, o_out_data, i_out_stall).
// Every input beat goes through three register stages: the framer event
// register, the coordinate product register and the output register. A beat
// that produces a result reaches the output through these registers in that
// order. One beat is accepted every cycle while no result waits on a stalled
// receiver; the pipeline moves as one and is held only at the output stage.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_stall goes high until the result is taken.
// Configuration writes (minimums and gains) are taken at any edge with
// i_cfg_we high, and are meant to happen while the pipeline is empty.
// Reset (i_rst_n low, synchronous) empties the pipeline, restarts framing,
// clears the poll waiting flag and loads the default calibration.
`default_nettype none

module touch_frame_decoder_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire tfd_pkg::t_in                 i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output tfd_pkg::t_out                     o_out_data,
    input  wire logic                         i_out_stall,
    input  wire logic                         i_cfg_we,
    input  wire logic [tfd_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [tfd_pkg::CFG_W-1:0]    i_cfg_data
);

    logic                          adv;
    logic                          accept;
    tfd_pkg::t_frame_ev            ev;
    logic [tfd_pkg::RAW_W-1:0]     r_x_min, r_y_min;
    logic [tfd_pkg::GAIN_W-1:0]    r_x_gain, r_y_gain;
    logic                          r_s2_valid, r_out_valid;
    logic [1:0]                    r_s2_kind, r_out_kind;
    logic                          r_s2_pressed, r_out_pressed;
    logic signed [tfd_pkg::FRAC_W-1:0] x_frac, y_frac;

    // pipeline advances unless a result is waiting on a stalled receiver
    assign adv        = !(r_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign accept     = i_in_valid && adv;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min  <= tfd_pkg::X_MIN_RESET;
            r_y_min  <= tfd_pkg::Y_MIN_RESET;
            r_x_gain <= tfd_pkg::X_GAIN_RESET;
            r_y_gain <= tfd_pkg::Y_GAIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfd_pkg::REG_X_MIN:  r_x_min  <= i_cfg_data[tfd_pkg::RAW_W-1:0];
                tfd_pkg::REG_Y_MIN:  r_y_min  <= i_cfg_data[tfd_pkg::RAW_W-1:0];
                tfd_pkg::REG_X_GAIN: r_x_gain <= i_cfg_data;
                tfd_pkg::REG_Y_GAIN: r_y_gain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tfd_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_accept (accept),
        .i_in     (i_in_data),
        .o_ev     (ev)
    );

    tfd_scaler u_scale_x (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_zero    (ev.kind != tfd_pkg::KIND_POINTER),
        .i_raw     (ev.raw_x),
        .i_minimum (r_x_min),
        .i_gain    (r_x_gain),
        .o_frac    (x_frac)
    );

    tfd_scaler u_scale_y (
        .i_clk     (i_clk),
        .i_adv     (adv),
        .i_zero    (ev.kind != tfd_pkg::KIND_POINTER),
        .i_raw     (ev.raw_y),
        .i_minimum (r_y_min),
        .i_gain    (r_y_gain),
        .o_frac    (y_frac)
    );

    // valid tracking alongside the scaler stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid  <= ev.valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // kind and button flag alongside the scaler stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_kind     <= ev.kind;
            r_s2_pressed  <= ev.pressed && (ev.kind == tfd_pkg::KIND_POINTER);
            r_out_kind    <= r_s2_kind;
            r_out_pressed <= r_s2_pressed;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_data.event_kind = r_out_kind;
    assign o_out_data.pressed    = r_out_pressed;
    assign o_out_data.x_fraction = x_frac;
    assign o_out_data.y_fraction = y_frac;

endmodule

`default_nettype wire

[dv/tb.sv]
// tb: self-checking testbench of touch_frame_decoder_top
// depends on tfd_pkg and the decoder RTL under src, nothing else

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfd_pkg::*;

    // mode value the decoder must ignore
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_BEATS  = 1950;
    localparam int SWEEP_PHASES  = 6;

    localparam logic [CFG_W-1:0] RAW_MAX  = 18'd4095;
    localparam logic [CFG_W-1:0] GAIN_MAX = 18'd262143;

    typedef logic [STORE_DEPTH-1:0][7:0] t_body;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    t_in                in_data;
    logic               in_stall;
    logic               out_valid;
    t_out               out_data;
    logic               out_stall;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    // predictor state: calibration, framing and poll flag
    logic [RAW_W-1:0]   x_min_q;
    logic [RAW_W-1:0]   y_min_q;
    logic [GAIN_W-1:0]  x_gain_q;
    logic [GAIN_W-1:0]  y_gain_q;
    int                 frame_pos;
    logic [7:0]         frame_bytes [STORE_DEPTH];
    logic [7:0]         frame_xor;
    logic               awaiting_ack;

    t_out               pending_events [$];
    int                 mismatches;
    int                 cycle_count;
    int                 beats_sent;
    int                 stall_left;
    bit                 gap_enable;
    bit                 stall_enable;

    touch_frame_decoder_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure: mostly short stalls, a few long ones
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (stall_enable && $urandom_range(99) < 30) begin
            out_stall <= 1'b1;
            stall_left = ($urandom_range(19) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // coordinate scaling: signed offset times reciprocal gain, round, saturate
    function automatic logic signed [FRAC_W-1:0] scale_coord(
        input logic [RAW_W-1:0]  raw,
        input logic [RAW_W-1:0]  minimum,
        input logic [GAIN_W-1:0] gain
    );
        longint offset;
        longint product;
        longint quotient;
        offset   = longint'(raw) - longint'(minimum);
        product  = offset * longint'(gain) + 64'sd8192;
        quotient = product >>> 14;
        if (quotient > 32767)
            quotient = 32767;
        else if (quotient < -32768)
            quotient = -32768;
        return quotient[FRAC_W-1:0];
    endfunction

    // append one expected result at the tail of the queue
    function automatic void expect_event(input t_out ev);
        pending_events = {pending_events, ev};
    endfunction

    // advance the decoder state by one accepted beat, queue its event if any
    function automatic void decode_beat(input t_in beat);
        t_out             ev;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        bit               good;
        ev = '0;
        case (beat.mode)
            MODE_RXFAIL: begin
                frame_pos     = 0;
                frame_xor     = 8'h00;
                ev.event_kind = KIND_RXFAIL;
                expect_event(ev);
            end
            MODE_POLL: begin
                if (!awaiting_ack) begin
                    awaiting_ack  = 1'b1;
                    ev.event_kind = KIND_POLL;
                    expect_event(ev);
                end
            end
            MODE_BYTE: begin
                if (frame_pos < STORE_DEPTH) begin
                    frame_bytes[frame_pos] = beat.rx_byte;
                    frame_xor = frame_xor ^ beat.rx_byte;
                    frame_pos++;
                end else begin
                    good      = (frame_xor == beat.rx_byte);
                    frame_pos = 0;
                    frame_xor = 8'h00;
                    if (!good) begin
                        ev.event_kind = KIND_CHECKSUM;
                        expect_event(ev);
                    end else if (frame_bytes[0] == HDR_POINTER &&
                                 frame_bytes[1] == HDR_POINTER) begin
                        raw_x = {frame_bytes[5][5:0], frame_bytes[6][5:0]};
                        raw_y = {frame_bytes[3][5:0], frame_bytes[4][5:0]};
                        ev.event_kind = KIND_POINTER;
                        ev.pressed    = (frame_bytes[2] == BTN_PRESSED);
                        ev.x_fraction = scale_coord(raw_x, x_min_q, x_gain_q);
                        ev.y_fraction = scale_coord(raw_y, y_min_q, y_gain_q);
                        awaiting_ack  = 1'b0;
                        expect_event(ev);
                    end else if (frame_bytes[0] == HDR_ACK0 &&
                                 frame_bytes[1] == HDR_ACK1) begin
                        awaiting_ack = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // report one field of a result against its expectation
    task automatic compare_field(input string name, input logic signed [FRAC_W:0] want,
                                 input logic signed [FRAC_W:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge clk) begin : check_results
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_events.size() == 0) begin
                $display("%0t: result expected none actual %p", $time, out_data);
                mismatches++;
            end else begin
                want = pending_events.pop_front();
                compare_field("event_kind", (FRAC_W+1)'(want.event_kind),
                              (FRAC_W+1)'(out_data.event_kind));
                compare_field("pressed", (FRAC_W+1)'(want.pressed),
                              (FRAC_W+1)'(out_data.pressed));
                compare_field("x_fraction", (FRAC_W+1)'(want.x_fraction),
                              (FRAC_W+1)'(out_data.x_fraction));
                compare_field("y_fraction", (FRAC_W+1)'(want.y_fraction),
                              (FRAC_W+1)'(out_data.y_fraction));
            end
        end
    end

    // idle gap after a beat: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!gap_enable || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // drive one beat, wait for it to be taken, then maybe idle
    task automatic send_beat(input logic [1:0] mode, input logic [7:0] value);
        t_in beat;
        int  gap;
        beat.mode    = mode;
        beat.rx_byte = value;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
        decode_beat(beat);
        if (mode != MODE_SPARE)
            beats_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop sending and let every expected result come out
    task automatic settle_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write, mirrored into the predictor
    task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_X_MIN:  x_min_q  = value[RAW_W-1:0];
            REG_Y_MIN:  y_min_q  = value[RAW_W-1:0];
            REG_X_GAIN: x_gain_q = value[GAIN_W-1:0];
            REG_Y_GAIN: y_gain_q = value[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_W-1:0] x_min, input logic [CFG_W-1:0] y_min,
                             input logic [CFG_W-1:0] x_gain, input logic [CFG_W-1:0] y_gain);
        program_reg(REG_X_MIN, x_min);
        program_reg(REG_Y_MIN, y_min);
        program_reg(REG_X_GAIN, x_gain);
        program_reg(REG_Y_GAIN, y_gain);
    endtask

    // seven body bytes followed by their xor, optionally corrupted
    task automatic send_frame(input t_body body, input logic [7:0] flip);
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            send_beat(MODE_BYTE, body[i]);
            sum = sum ^ body[i];
        end
        send_beat(MODE_BYTE, sum ^ flip);
    endtask

    // pointer frame body; the two unused bits of each coordinate byte are random
    function automatic t_body pointer_body(input logic [RAW_W-1:0] raw_x,
                                           input logic [RAW_W-1:0] raw_y,
                                           input logic [7:0] button);
        t_body      body;
        logic [7:0] noise;
        noise   = 8'($urandom);
        body[0] = HDR_POINTER;
        body[1] = HDR_POINTER;
        body[2] = button;
        body[3] = {noise[7:6], raw_y[11:6]};
        body[4] = {noise[5:4], raw_y[5:0]};
        body[5] = {noise[3:2], raw_x[11:6]};
        body[6] = {noise[1:0], raw_x[5:0]};
        return body;
    endfunction

    function automatic t_body ack_body();
        t_body body;
        body    = {$urandom, 24'($urandom)};
        body[0] = HDR_ACK0;
        body[1] = HDR_ACK1;
        return body;
    endfunction

    // frame of no known type most of the time, with near-miss headers
    function automatic t_body other_body();
        t_body body;
        body = {$urandom, 24'($urandom)};
        case ($urandom_range(3))
            0: body[0] = HDR_POINTER;
            1: body[0] = HDR_ACK0;
            default: ;
        endcase
        case ($urandom_range(3))
            0: body[1] = HDR_POINTER;
            1: body[1] = HDR_ACK1;
            default: ;
        endcase
        return body;
    endfunction

    // raw coordinate: full range, near the minimum, or an end of the range
    function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] minimum);
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return RAW_W'($urandom);
        if (r < 7)
            return minimum + RAW_W'($urandom_range(64)) - RAW_W'(32);
        if (r < 8)
            return '0;
        if (r < 9)
            return '1;
        return minimum;
    endfunction

    function automatic logic [7:0] pick_button();
        int r;
        r = $urandom_range(3);
        if (r < 2)
            return BTN_PRESSED;
        if (r < 3)
            return BTN_PRESSED ^ (8'h01 << $urandom_range(7));
        return 8'($urandom);
    endfunction

    function automatic t_body random_pointer();
        return pointer_body(pick_raw(x_min_q), pick_raw(y_min_q), pick_button());
    endfunction

    // poll requests are gated by the waiting flag; an ack clears it, a receive failure does not
    task automatic test_poll_gating();
        send_beat(MODE_POLL, 8'h00);
        send_beat(MODE_POLL, 8'hFF);
        send_beat(MODE_RXFAIL, 8'hA5);
        send_beat(MODE_POLL, 8'h5A);
        send_frame(ack_body(), 8'h00);
        send_beat(MODE_POLL, 8'h00);
    endtask

    // coordinate extremes with masked upper bits, pressed and released
    task automatic test_pointer_extremes();
        t_body body;
        body[0] = HDR_POINTER;
        body[1] = HDR_POINTER;
        body[2] = BTN_PRESSED;
        body[3] = 8'hC0;
        body[4] = 8'h40;
        body[5] = 8'hFF;
        body[6] = 8'hFF;
        send_frame(body, 8'h00);
        body[2] = 8'h50;
        body[3] = 8'h3F;
        body[4] = 8'h3F;
        body[5] = 8'h00;
        body[6] = 8'h00;
        send_frame(body, 8'h00);
    endtask

    // bad checksum, frame of no known type, ignored mode, broken frame
    task automatic test_framing_faults();
        t_body body;
        send_beat(MODE_POLL, 8'h00);
        send_frame(ack_body(), 8'h80);
        send_beat(MODE_POLL, 8'h00);
        body    = '0;
        body[0] = 8'hCE;
        send_frame(body, 8'h00);
        send_beat(MODE_SPARE, 8'hFF);
        send_beat(MODE_BYTE, HDR_POINTER);
        send_beat(MODE_BYTE, HDR_POINTER);
        send_beat(MODE_RXFAIL, 8'h00);
        send_frame(random_pointer(), 8'h00);
    endtask

    // mostly well-formed frames with random content, plus noise
    task automatic send_random_traffic(input int budget);
        int    start;
        int    pick;
        int    count;
        t_body body;
        start = beats_sent;
        while (beats_sent - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_frame(random_pointer(), 8'h00);
            end else if (pick < 50) begin
                send_frame(ack_body(), 8'h00);
            end else if (pick < 55) begin
                send_frame(other_body(), 8'h00);
            end else if (pick < 65) begin
                body = (pick < 60) ? random_pointer() : ack_body();
                send_frame(body, 8'($urandom_range(1, 255)));
            end else if (pick < 72) begin
                body  = random_pointer();
                count = $urandom_range(0, STORE_DEPTH);
                for (int i = 0; i < count; i++) begin
                    send_beat(MODE_BYTE, (i < STORE_DEPTH) ? body[i] : 8'h00);
                end
                send_beat(MODE_RXFAIL, 8'($urandom));
            end else if (pick < 87) begin
                send_beat(MODE_POLL, 8'($urandom));
            end else if (pick < 92) begin
                send_beat(MODE_RXFAIL, 8'($urandom));
            end else if (pick < 96) begin
                // stray byte shifts framing until the next restart
                send_beat(MODE_BYTE, 8'($urandom));
                if ($urandom_range(1) == 1)
                    send_beat(MODE_RXFAIL, 8'($urandom));
            end else if (pick < 98) begin
                send_beat(MODE_SPARE, 8'($urandom));
            end else begin
                settle_pipeline();
            end
        end
    endtask

    // random traffic under calibration extremes and random calibrations
    task automatic test_calibration_sweep();
        int span_x;
        int span_y;
        for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
            settle_pipeline();
            span_x = $urandom_range(1100, 4095);
            span_y = $urandom_range(1100, 4095);
            case (phase)
                0: configure('0, '0, GAIN_MAX, GAIN_MAX);
                1: configure(RAW_MAX, RAW_MAX, GAIN_MAX, GAIN_MAX);
                2: configure(RAW_MAX, '0, '0, '0);
                3: configure(CFG_W'(X_MIN_RESET), CFG_W'(Y_MIN_RESET),
                             CFG_W'(X_GAIN_RESET), CFG_W'(Y_GAIN_RESET));
                4: configure(CFG_W'($urandom_range(1000)), CFG_W'($urandom_range(1000)),
                             CFG_W'((1 << 28) / span_x), CFG_W'((1 << 28) / span_y));
                default: configure(CFG_W'($urandom), CFG_W'($urandom),
                                   CFG_W'($urandom), CFG_W'($urandom));
            endcase
            // every third phase runs with no idling on either side
            gap_enable   = (phase % 3 != 2);
            stall_enable = (phase % 3 != 2);
            send_random_traffic(RANDOM_BEATS / SWEEP_PHASES);
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        cycle_count  = 0;
        beats_sent   = 0;
        stall_left   = 0;
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
        x_min_q      = X_MIN_RESET;
        y_min_q      = Y_MIN_RESET;
        x_gain_q     = X_GAIN_RESET;
        y_gain_q     = Y_GAIN_RESET;
        frame_pos    = 0;
        frame_xor    = 8'h00;
        awaiting_ack = 1'b0;
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_poll_gating();
        test_pointer_extremes();
        test_framing_faults();
        test_calibration_sweep();

        settle_pipeline();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
